@@ rtl/bpr_pkg.sv @@
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared types and constants for the branch resolve and predictor update block.
// Table depths are powers of two; the target and local history tables are indexed by low address bits.
// ----------------------------------------------------------------------------
package bpr_pkg;

  localparam int unsigned AddrW          = 32;
  localparam int unsigned HistW          = 10;
  localparam int unsigned CtrW           = 2;
  localparam int unsigned ModeW          = 3;
  localparam int unsigned TargetEntries  = 1024;
  localparam int unsigned CounterEntries = 1024;
  localparam int unsigned LocalEntries   = 256;
  localparam logic [AddrW-1:0] PcStep    = AddrW'(4);
  localparam logic [CtrW-1:0]  CtrMax    = CtrW'(3);
  localparam logic [CtrW-1:0]  CtrOne    = CtrW'(1);

  typedef enum logic [ModeW-1:0] {
    MODE_ANT    = 3'd0,
    MODE_AT     = 3'd1,
    MODE_BTFN   = 3'd2,
    MODE_ONEBIT = 3'd3,
    MODE_TWOBIT = 3'd4,
    MODE_GSHARE = 3'd5,
    MODE_LOCAL  = 3'd6
  } mode_e;

  typedef struct packed {
    logic [AddrW-1:0] branch_pc;
    logic             actual_taken;
    logic [AddrW-1:0] target_address;
  } in_item_t;

  typedef struct packed {
    logic             mispredicted;
    logic [AddrW-1:0] redirect_pc;
    logic [AddrW-1:0] correct_total;
    logic [AddrW-1:0] mispredict_total;
  } out_item_t;

  typedef struct packed {
    logic             pred;
    logic             tb_we;
    logic             ctr_we;
    logic [CtrW-1:0]  ctr_wdata;
    logic             lh_we;
    logic [HistW-1:0] lh_wdata;
    logic             gh_we;
  } upd_t;

endpackage

@@ rtl/bpr_chan_if.sv @@
// ----------------------------------------------------------------------------
// bpr_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface bpr_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

@@ rtl/bpr_ram.sv @@
// ----------------------------------------------------------------------------
// bpr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bpr_decide.sv @@
// ----------------------------------------------------------------------------
// bpr_decide
// Prediction for the selected scheme and the table updates it implies.
// ----------------------------------------------------------------------------
module bpr_decide import bpr_pkg::*; (
  input  logic [ModeW-1:0] mode_i,
  input  in_item_t         item_i,
  input  logic [AddrW-1:0] entry_i,
  input  logic [CtrW-1:0]  ctr_i,
  input  logic [HistW-1:0] lh_i,
  output upd_t             upd_o
);

  logic            entry_nz;
  logic            taken;
  logic [CtrW-1:0] ctr_sat;

  assign entry_nz = (entry_i != '0);
  assign taken    = item_i.actual_taken;

  always_comb begin
    if (taken) begin
      ctr_sat = (ctr_i == CtrMax) ? CtrMax : ctr_i + CtrW'(1);
    end else begin
      ctr_sat = (ctr_i == '0) ? '0 : ctr_i - CtrW'(1);
    end
  end

  always_comb begin
    upd_o          = '0;
    upd_o.lh_wdata = {lh_i[HistW-2:0], taken};
    case (mode_i)
      MODE_AT: begin
        upd_o.pred  = entry_nz;
        upd_o.tb_we = !entry_nz && taken;
      end
      MODE_BTFN: begin
        upd_o.pred  = entry_nz && (entry_i < item_i.branch_pc);
        upd_o.tb_we = !upd_o.pred && taken && (item_i.target_address < item_i.branch_pc);
      end
      MODE_ONEBIT: begin
        upd_o.ctr_wdata = {1'b0, taken};
        if (entry_nz) begin
          upd_o.pred   = (ctr_i == CtrOne);
          upd_o.ctr_we = (upd_o.pred != taken);
        end else begin
          upd_o.ctr_we = 1'b1;
          upd_o.tb_we  = taken;
        end
      end
      MODE_TWOBIT, MODE_GSHARE, MODE_LOCAL: begin
        upd_o.pred      = ctr_i[CtrW-1];
        upd_o.ctr_we    = 1'b1;
        upd_o.ctr_wdata = ctr_sat;
        upd_o.tb_we     = !entry_nz && taken;
        upd_o.gh_we     = (mode_i == MODE_GSHARE);
        upd_o.lh_we     = (mode_i == MODE_LOCAL);
      end
      default: begin
        upd_o.pred = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/branch_predictor_resolve_top.sv @@
// ----------------------------------------------------------------------------
// branch_predictor_resolve_top
// Checks resolved branches against the selected predictor and trains it.
//
// in_i carries one resolved branch per item (pc, outcome, target); out_o
// returns one result per item: mispredict flag, redirect pc (zero when the
// prediction was right) and the running correct and mispredict totals.
// cfg_i writes the 3-bit predictor mode; write it only while no branch is
// in flight. After acceptance the result is formed in steps:
// the target and local history tables are read at acceptance, the counter
// table is read in the next cycle (its index may depend on the local
// history), and the update state decides and writes the tables back.
// A new branch is taken only once the previous one has written back.
// After reset a clearing pass zeroes all tables, one entry per cycle over
// as many entries as the deepest table holds (1024 with the default sizes);
// in_i.ready stays low meanwhile. A stalled out_o holds its result; the
// block can still accept the next branch but will not write it back until
// the output register is free.
// ----------------------------------------------------------------------------
module branch_predictor_resolve_top import bpr_pkg::*; #(
  parameter int unsigned TargetEntriesP  = TargetEntries,
  parameter int unsigned CounterEntriesP = CounterEntries,
  parameter int unsigned LocalEntriesP   = LocalEntries
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpr_chan_if.sink   in_i,
  bpr_chan_if.source out_o,
  bpr_chan_if.sink   cfg_i
);

  localparam int unsigned TiW = $clog2(TargetEntriesP);
  localparam int unsigned CiW = $clog2(CounterEntriesP);
  localparam int unsigned LiW = $clog2(LocalEntriesP);
  localparam int unsigned MaxTc = (TargetEntriesP > CounterEntriesP) ?
                                  TargetEntriesP : CounterEntriesP;
  localparam int unsigned MaxEntries = (MaxTc > LocalEntriesP) ? MaxTc : LocalEntriesP;
  localparam int unsigned ClrW = $clog2(MaxEntries);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_CTR   = 4'b0100,
    ST_UPD   = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [ClrW-1:0]  clr_q, clr_d;
  logic [ModeW-1:0] mode_q;
  in_item_t         item_q;
  logic [HistW-1:0] gh_q;
  logic [CiW-1:0]   ci_q, ci_d;
  logic [AddrW-1:0] correct_q, mispred_q;
  logic             out_valid_q;
  out_item_t        out_q, out_d;

  logic             in_acc;
  logic             clearing;
  logic             upd_go;
  upd_t             upd;
  logic [AddrW-1:0] tb_rdata;
  logic [CtrW-1:0]  ctr_rdata;
  logic [HistW-1:0] lh_rdata;
  logic [AddrW-1:0] gs_idx;
  logic [AddrW-1:0] lh_ext;
  logic             mis;

  assign clearing    = (state_q == ST_CLEAR);
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign upd_go      = (state_q == ST_UPD) && (!out_valid_q || out_o.ready);

  assign gs_idx = item_q.branch_pc ^ {{(AddrW-HistW){1'b0}}, gh_q};
  assign lh_ext = {{(AddrW-HistW){1'b0}}, lh_rdata};

  always_comb begin
    case (mode_q)
      MODE_GSHARE: ci_d = gs_idx[CiW-1:0];
      MODE_LOCAL:  ci_d = lh_ext[CiW-1:0];
      default:     ci_d = item_q.branch_pc[CiW-1:0];
    endcase
  end

  bpr_ram #(.Width(AddrW), .Depth(TargetEntriesP)) u_tb_ram (
    .clk_i   (clk_i),
    .we_i    (clearing || (upd_go && upd.tb_we)),
    .waddr_i (clearing ? clr_q[TiW-1:0] : item_q.branch_pc[TiW-1:0]),
    .wdata_i (clearing ? '0 : item_q.target_address),
    .re_i    (in_acc),
    .raddr_i (in_i.data.branch_pc[TiW-1:0]),
    .rdata_o (tb_rdata)
  );

  bpr_ram #(.Width(HistW), .Depth(LocalEntriesP)) u_lh_ram (
    .clk_i   (clk_i),
    .we_i    (clearing || (upd_go && upd.lh_we)),
    .waddr_i (clearing ? clr_q[LiW-1:0] : item_q.branch_pc[LiW-1:0]),
    .wdata_i (clearing ? '0 : upd.lh_wdata),
    .re_i    (in_acc),
    .raddr_i (in_i.data.branch_pc[LiW-1:0]),
    .rdata_o (lh_rdata)
  );

  bpr_ram #(.Width(CtrW), .Depth(CounterEntriesP)) u_ctr_ram (
    .clk_i   (clk_i),
    .we_i    (clearing || (upd_go && upd.ctr_we)),
    .waddr_i (clearing ? clr_q[CiW-1:0] : ci_q),
    .wdata_i (clearing ? '0 : upd.ctr_wdata),
    .re_i    (state_q == ST_CTR),
    .raddr_i (ci_d),
    .rdata_o (ctr_rdata)
  );

  bpr_decide u_decide (
    .mode_i  (mode_q),
    .item_i  (item_q),
    .entry_i (tb_rdata),
    .ctr_i   (ctr_rdata),
    .lh_i    (lh_rdata),
    .upd_o   (upd)
  );

  assign mis = (upd.pred != item_q.actual_taken);

  always_comb begin
    out_d.mispredicted     = mis;
    out_d.redirect_pc      = '0;
    if (mis) begin
      out_d.redirect_pc = item_q.actual_taken ? item_q.target_address
                                              : item_q.branch_pc + PcStep;
    end
    out_d.correct_total    = mis ? correct_q : correct_q + AddrW'(1);
    out_d.mispredict_total = mis ? mispred_q + AddrW'(1) : mispred_q;
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ClrW'(1);
        if (clr_q == ClrW'(MaxEntries - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_CTR;
        end
      end
      ST_CTR: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      mode_q      <= MODE_ANT;
      gh_q        <= '0;
      correct_q   <= '0;
      mispred_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_i.valid && cfg_i.ready) begin
        mode_q <= cfg_i.data;
      end
      if (upd_go) begin
        correct_q   <= out_d.correct_total;
        mispred_q   <= out_d.mispredict_total;
        out_valid_q <= 1'b1;
        if (upd.gh_we) begin
          gh_q <= {gh_q[HistW-2:0], item_q.actual_taken};
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_i.data;
    end
    if (state_q == ST_CTR) begin
      ci_q <= ci_d;
    end
    if (upd_go) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_CTR))
    else $error("accepted branch did not start the counter read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_i.ready)
    else $error("input ready during table clearing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_go |=> ((correct_q + mispred_q) == ($past(correct_q + mispred_q) + AddrW'(1))))
    else $error("totals did not advance by one per result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.mispredicted) |-> (out_o.data.redirect_pc == '0))
    else $error("redirect pc set on a correct prediction");

endmodule
